### sv/mmnq_pkg.sv
`timescale 1ns / 1ps

package mmnq_pkg;

	// sample and index widths
	localparam int SampleW = 16;
	localparam int LevelW = 4;
	// width of the numerator of the level divide: (levels - 1) * offset
	localparam int DivW = SampleW + LevelW;
	// index given to every element of a flat set
	localparam logic [LevelW-1:0] FlatLevel = 4'd7;

	// one input transfer
	typedef struct packed {
		logic signed [SampleW-1:0] sample;
		logic                      is_final;
	} feed_t;

	// one output transfer
	typedef struct packed {
		logic [2*LevelW-1:0]       packed_pair;
		logic signed [SampleW-1:0] range_min;
		logic signed [SampleW-1:0] range_max;
		logic                      end_of_run;
	} pack_t;

	// level divider request and response
	typedef struct packed {
		logic                start;
		logic [DivW-1:0]     dividend;
		logic [SampleW-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [LevelW-1:0] level;
	} div_rsp_t;

endpackage

### sv/min_max_nibble_quantizer.sv
`timescale 1ns / 1ps

// Min/max 4-bit quantizer.
// The feed channel takes one signed 16-bit sample per transfer; is_final closes
// the set. Samples load at one per cycle into an internal sample memory while
// the running minimum and maximum are tracked. Samples beyond MAX_ELEMENTS are
// dropped, but a final mark on one still closes the set.
// After the final transfer, feed_stall stays high while the set is drained:
// each stored sample is read back through the registered memory port and its
// level floor(15*(v-min)/(max-min)) comes from a divider retiring two quotient
// bits per cycle; a flat set skips the divide steps and gets level 7, and each
// packed byte takes its own emit step. The pack channel carries one byte per
// element pair, low nibble first, with min and max on every byte and
// end_of_run on the last byte. The output register holds the byte while
// pack_stall is high; the drain waits only when the next byte is ready and the
// register is still full. Loading of the next set starts in the cycle after
// the last byte enters the output register.
// Reset clears the count, min and max and the handshake state; the sample
// memory is not cleared and needs no clearing pass.
module min_max_nibble_quantizer
	import mmnq_pkg::*;
#(
	parameter int MAX_ELEMENTS = 128
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  feed_valid,
	output logic  feed_stall,
	input  feed_t feed,
	output logic  pack_valid,
	input  logic  pack_stall,
	output pack_t pack
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [2:0] {
		S_LOAD,
		S_READ,
		S_START,
		S_DIV,
		S_EMIT
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic signed [SampleW-1:0] min_q;
	logic signed [SampleW-1:0] max_q;
	logic [LevelW-1:0]         lo_nib_q;
	logic [LevelW-1:0]         hi_nib_q;
	pack_t                     out_q;
	logic                      out_valid_q;

	logic               feed_fire;
	logic               room;
	logic               last_elem;
	logic               out_free;
	logic [SampleW-1:0] rd_data;
	logic [SampleW-1:0] span;
	logic [SampleW-1:0] off;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// handshake and bookkeeping
	assign feed_stall = (state_q != S_LOAD);
	assign feed_fire = feed_valid && !feed_stall;
	assign room = (count_q < CW'(MAX_ELEMENTS));
	assign last_elem = ((idx_q + CW'(1)) >= count_q);
	assign out_free = !out_valid_q || !pack_stall;

	// sample memory
	mmnq_store #(
		.DEPTH(MAX_ELEMENTS)
	) u_store (
		.clk    (clk),
		.wr_en  (feed_fire && room),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(feed.sample),
		.rd_en  (state_q == S_READ),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// level divide request: 15 * (v - min) over (max - min)
	always_comb begin
		span = SampleW'(max_q - min_q);
		off = SampleW'(rd_data - min_q);
		div_req.start = (state_q == S_START);
		div_req.dividend = {off, {LevelW{1'b0}}} - DivW'(off);
		div_req.divisor = span;
	end

	mmnq_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// load and drain sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			idx_q <= '0;
			min_q <= '0;
			max_q <= '0;
			lo_nib_q <= '0;
			hi_nib_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register fills on a byte, empties on a transfer
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!pack_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (feed_fire) begin
						if (room) begin
							count_q <= count_q + CW'(1);
							if (count_q == '0) begin
								min_q <= feed.sample;
								max_q <= feed.sample;
							end else begin
								if ($signed(feed.sample) < min_q) begin
									min_q <= feed.sample;
								end
								if ($signed(feed.sample) > max_q) begin
									max_q <= feed.sample;
								end
							end
						end
						if (feed.is_final) begin
							idx_q <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (!idx_q[0]) begin
							lo_nib_q <= div_rsp.level;
							hi_nib_q <= '0;
							if (last_elem) begin
								state_q <= S_EMIT;
							end else begin
								idx_q <= idx_q + CW'(1);
								state_q <= S_READ;
							end
						end else begin
							hi_nib_q <= div_rsp.level;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.packed_pair <= {hi_nib_q, lo_nib_q};
						out_q.range_min <= min_q;
						out_q.range_max <= max_q;
						out_q.end_of_run <= last_elem;
						if (last_elem) begin
							count_q <= '0;
							min_q <= '0;
							max_q <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q <= idx_q + CW'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign pack_valid = out_valid_q;
	assign pack = out_q;

	// fill count never passes the memory depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ELEMENTS))
		else $error("sample count beyond memory depth");

	// a final transfer starts the drain
	assert property (@(posedge clk) disable iff (!arst_n)
		feed_fire && feed.is_final |=> feed_stall && state_q == S_READ)
		else $error("final transfer did not start drain");

	// divider results arrive only while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider result outside wait state");

	// the last byte of a set returns to loading with a cleared count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && out_free && last_elem
		|=> state_q == S_LOAD && count_q == '0 && pack_valid && pack.end_of_run)
		else $error("end of set not handled");

endmodule

### sv/mmnq_store.sv
`timescale 1ns / 1ps

module mmnq_store
	import mmnq_pkg::*;
#(
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [SampleW-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [SampleW-1:0] rd_data
);

	logic [SampleW-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/mmnq_div.sv
`timescale 1ns / 1ps

module mmnq_div
	import mmnq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic               busy_q;
	logic               step_q;
	logic               done_q;
	logic [DivW-1:0]    rem_q;
	logic [SampleW-1:0] den_q;
	logic [LevelW-1:0]  quo_q;

	logic [DivW-1:0] d_hi;
	logic [DivW-1:0] d_lo;
	logic [DivW-1:0] rem_a;
	logic [DivW-1:0] rem_b;
	logic            bit_hi;
	logic            bit_lo;

	// two restoring steps per cycle: quotient bits 3,2 then 1,0
	always_comb begin
		d_hi = step_q ? (DivW'(den_q) << 1) : (DivW'(den_q) << 3);
		d_lo = step_q ? DivW'(den_q) : (DivW'(den_q) << 2);
		bit_hi = (rem_q >= d_hi);
		rem_a = bit_hi ? (rem_q - d_hi) : rem_q;
		bit_lo = (rem_a >= d_lo);
		rem_b = bit_lo ? (rem_a - d_lo) : rem_a;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			// flat request finishes at once, others after the second step
			done_q <= req.start ? (req.divisor == '0) : (busy_q && step_q);
			if (req.start) begin
				step_q <= 1'b0;
				busy_q <= (req.divisor != '0);
			end else if (busy_q) begin
				step_q <= ~step_q;
				if (step_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			den_q <= req.divisor;
			quo_q <= (req.divisor == '0) ? FlatLevel : '0;
		end else if (busy_q) begin
			rem_q <= rem_b;
			quo_q <= {quo_q[1:0], bit_hi, bit_lo};
		end
	end

	assign rsp.done = done_q;
	assign rsp.level = quo_q;

endmodule
